// ===== design/cau_pkg.sv =====
// Shared types and constants of the complex arithmetic unit.
// Holds the word layouts, the operation codes and the derived widths.
// No dependencies.
package cau_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 16;

  // Signed product of two data words, and the signed sum of two such products.
  localparam int unsigned ProdWidth = 2 * DataWidth;
  localparam int unsigned SumWidth  = 2 * DataWidth + 1;
  // Divisor (twice the squared norm), division remainder and root residue.
  localparam int unsigned DvsWidth  = 2 * DataWidth + 1;
  localparam int unsigned RemWidth  = 3 * DataWidth + FracBits + 2;
  localparam int unsigned SqWidth   = 2 * DataWidth + 1;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_MAG  = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]                  op;
    logic signed [DataWidth-1:0] a_real;
    logic signed [DataWidth-1:0] a_imag;
    logic signed [DataWidth-1:0] b_real;
    logic signed [DataWidth-1:0] b_imag;
  } in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] res_real;
    logic signed [DataWidth-1:0] res_imag;
    logic                        div_zero;
    logic                        saturated;
  } out_t;

endpackage

// ===== design/complex_arith_unit_core.sv =====
// Complex arithmetic unit: pipelined add, subtract, multiply, divide,
// conjugate and magnitude on signed fixed-point complex words.
// Depends on cau_pkg.
//
// Usage
//   The input channel (in_valid_i, in_stall_o, in_word_i) carries one op code
//   and two complex operands a and b per word. The output channel
//   (out_valid_o, out_stall_i, out_word_o) returns one result word per input
//   word, in order, with a divide-by-zero flag and a saturation flag.
//   A word is accepted at a rising edge where valid is high and stall is low.
//   Throughput is one word per cycle while the receiver does not stall.
//   The division and square-root units resolve one quotient bit and one
//   root bit per pipeline stage; results are shown from an output register.
//   The multipliers sit in a single stage, followed by an add stage and a
//   rounding/setup stage before the iteration stages.
//   Reset empties the pipeline: all valid bits clear, no result is shown.
//   When the receiver stalls while a result waits, the whole pipeline holds
//   and in_stall_o rises in the same cycle; nothing is lost or repeated.
module complex_arith_unit_core
  import cau_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_word_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_word_o
);

  localparam int unsigned DW = DataWidth;

  localparam logic signed [SumWidth-1:0] SMax =
    $signed({{(SumWidth-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam logic signed [SumWidth-1:0] SMin = ~SMax;
  localparam logic [DW-1:0] PosLim = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] NegLim = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic                 sat;
    logic signed [DW-1:0] val;
  } res_t;

  // Results and flags that travel alongside the arithmetic.
  typedef struct packed {
    logic [2:0]           op;
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 sat;
    logic                 dz;
  } side_t;

  typedef struct packed {
    side_t                       sd;
    logic signed [ProdWidth-1:0] p_rr;
    logic signed [ProdWidth-1:0] p_ii;
    logic signed [ProdWidth-1:0] p_ri;
    logic signed [ProdWidth-1:0] p_ir;
    logic signed [ProdWidth-1:0] p_bb;
    logic signed [ProdWidth-1:0] p_cc;
  } s2_t;

  typedef struct packed {
    side_t                      sd;
    logic signed [SumWidth-1:0] sum_re;
    logic signed [SumWidth-1:0] sum_im;
    logic [ProdWidth-1:0]       den;
  } s3_t;

  typedef struct packed {
    side_t                sd;
    logic                 neg_re;
    logic                 neg_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic [RemWidth-1:0]  rem_re;
    logic [RemWidth-1:0]  rem_im;
    logic [DW-1:0]        q_re;
    logic [DW-1:0]        q_im;
    logic [DvsWidth-1:0]  dvs;
    logic [SqWidth-1:0]   sq_e;
    logic [DW-1:0]        sq_r;
  } it_t;

  function automatic res_t sat_s(logic signed [SumWidth-1:0] v);
    res_t r;
    r.sat = 1'b0;
    r.val = v[DW-1:0];
    if (v > SMax) begin
      r.sat = 1'b1;
      r.val = PosLim;
    end else if (v < SMin) begin
      r.sat = 1'b1;
      r.val = NegLim;
    end
    return r;
  endfunction

  function automatic res_t sat_m(logic neg, logic ovf, logic [DW-1:0] q);
    res_t          r;
    logic [DW-1:0] lim;
    logic [DW-1:0] v;
    lim   = neg ? NegLim : PosLim;
    r.sat = ovf || (q > lim);
    v     = r.sat ? lim : q;
    r.val = neg ? -v : v;
    return r;
  endfunction

  // One restoring step for both division lanes and the square root.
  function automatic it_t it_step(it_t s, int unsigned i);
    it_t                o;
    logic [RemWidth-1:0] dt;
    logic [SqWidth-1:0]  st;
    o  = s;
    dt = RemWidth'(s.dvs) << i;
    if (s.rem_re >= dt) begin
      o.rem_re = s.rem_re - dt;
      o.q_re   = s.q_re | (DW'(1) << i);
    end
    if (s.rem_im >= dt) begin
      o.rem_im = s.rem_im - dt;
      o.q_im   = s.q_im | (DW'(1) << i);
    end
    // The residue holds s - r*r; adding bit i costs r*2^(i+1) + 2^(2i).
    st = (SqWidth'(s.sq_r) << (i + 1)) + (SqWidth'(1) << (2 * i));
    if (s.sq_e >= st) begin
      o.sq_e = s.sq_e - st;
      o.sq_r = s.sq_r | (DW'(1) << i);
    end
    return o;
  endfunction

  logic en;
  logic s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  in_t  s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  it_t  it_d;
  it_t  it_q   [DW+1];
  logic itv_q  [DW+1];
  out_t out_d, out_q;

  // The pipeline advances unless a finished word is held by the receiver.
  assign en          = !(out_vld_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // Stage 2: products and the plain add, subtract and conjugate results.
  always_comb begin
    logic signed [DW-1:0] mr;
    logic signed [DW-1:0] mi;
    res_t                 r0;
    res_t                 r1;
    mr = s1_q.b_real;
    mi = s1_q.b_imag;
    if (s1_q.op == OP_MAG) begin
      mr = s1_q.a_real;
      mi = s1_q.a_imag;
    end
    s2_d.p_rr = s1_q.a_real * mr;
    s2_d.p_ii = s1_q.a_imag * mi;
    s2_d.p_ri = s1_q.a_real * s1_q.b_imag;
    s2_d.p_ir = s1_q.a_imag * s1_q.b_real;
    s2_d.p_bb = s1_q.b_real * s1_q.b_real;
    s2_d.p_cc = s1_q.b_imag * s1_q.b_imag;
    r0 = '0;
    r1 = '0;
    unique case (s1_q.op)
      OP_ADD: begin
        r0 = sat_s(SumWidth'(s1_q.a_real) + SumWidth'(s1_q.b_real));
        r1 = sat_s(SumWidth'(s1_q.a_imag) + SumWidth'(s1_q.b_imag));
      end
      OP_SUB: begin
        r0 = sat_s(SumWidth'(s1_q.a_real) - SumWidth'(s1_q.b_real));
        r1 = sat_s(SumWidth'(s1_q.a_imag) - SumWidth'(s1_q.b_imag));
      end
      OP_CONJ: begin
        r0 = sat_s(SumWidth'(s1_q.a_real));
        r1 = sat_s(-SumWidth'(s1_q.a_imag));
      end
      default: begin
        r0 = '0;
        r1 = '0;
      end
    endcase
    s2_d.sd.op  = s1_q.op;
    s2_d.sd.re  = r0.val;
    s2_d.sd.im  = r1.val;
    s2_d.sd.sat = r0.sat | r1.sat;
    s2_d.sd.dz  = 1'b0;
  end

  // Stage 3: sums of products and the squared norm of b.
  always_comb begin
    s3_d.sd     = s2_q.sd;
    s3_d.sum_re = '0;
    s3_d.sum_im = '0;
    s3_d.den    = $unsigned(s2_q.p_bb) + $unsigned(s2_q.p_cc);
    unique case (s2_q.sd.op)
      OP_MUL: begin
        s3_d.sum_re = SumWidth'(s2_q.p_rr) - SumWidth'(s2_q.p_ii);
        s3_d.sum_im = SumWidth'(s2_q.p_ri) + SumWidth'(s2_q.p_ir);
      end
      OP_DIV: begin
        s3_d.sum_re = SumWidth'(s2_q.p_rr) + SumWidth'(s2_q.p_ii);
        s3_d.sum_im = SumWidth'(s2_q.p_ir) - SumWidth'(s2_q.p_ri);
      end
      OP_MAG: begin
        s3_d.sum_re = SumWidth'(s2_q.p_rr) + SumWidth'(s2_q.p_ii);
      end
      default: begin
        s3_d.sum_re = '0;
      end
    endcase
  end

  // Stage 4: product rounding, and setup of the division and root units.
  always_comb begin
    logic signed [SumWidth-1:0] x_re;
    logic signed [SumWidth-1:0] x_im;
    logic [SumWidth-1:0]        m_re;
    logic [SumWidth-1:0]        m_im;
    res_t                       r0;
    res_t                       r1;
    logic [RemWidth-1:0]        top;
    x_re = (s3_q.sum_re + (SumWidth'(1) <<< (FracBits - 1))) >>> FracBits;
    x_im = (s3_q.sum_im + (SumWidth'(1) <<< (FracBits - 1))) >>> FracBits;
    r0   = sat_s(x_re);
    r1   = sat_s(x_im);
    it_d        = '0;
    it_d.sd     = s3_q.sd;
    if (s3_q.sd.op == OP_MUL) begin
      it_d.sd.re  = r0.val;
      it_d.sd.im  = r1.val;
      it_d.sd.sat = r0.sat | r1.sat;
    end
    if (s3_q.sd.op == OP_DIV) begin
      it_d.sd.dz = (s3_q.den == '0);
    end
    it_d.neg_re = s3_q.sum_re[SumWidth-1];
    it_d.neg_im = s3_q.sum_im[SumWidth-1];
    m_re = it_d.neg_re ? $unsigned(-s3_q.sum_re) : $unsigned(s3_q.sum_re);
    m_im = it_d.neg_im ? $unsigned(-s3_q.sum_im) : $unsigned(s3_q.sum_im);
    // Adding the norm before dividing by twice the norm rounds half away.
    it_d.rem_re = (RemWidth'(m_re) << (FracBits + 1)) + RemWidth'(s3_q.den);
    it_d.rem_im = (RemWidth'(m_im) << (FracBits + 1)) + RemWidth'(s3_q.den);
    it_d.dvs    = DvsWidth'(s3_q.den) << 1;
    top         = RemWidth'(it_d.dvs) << DW;
    it_d.ovf_re = (it_d.rem_re >= top);
    it_d.ovf_im = (it_d.rem_im >= top);
    it_d.sq_e   = SqWidth'($unsigned(s3_q.sum_re));
  end

  // Final stage: clip quotient and root, select the result word.
  always_comb begin
    it_t  f;
    res_t r0;
    res_t r1;
    f  = it_q[DW];
    r0 = sat_m(f.neg_re, f.ovf_re, f.q_re);
    r1 = sat_m(f.neg_im, f.ovf_im, f.q_im);
    out_d.res_real  = f.sd.re;
    out_d.res_imag  = f.sd.im;
    out_d.div_zero  = f.sd.dz;
    out_d.saturated = f.sd.sat;
    if (f.sd.op == OP_DIV) begin
      if (f.sd.dz) begin
        out_d.res_real  = '0;
        out_d.res_imag  = '0;
        out_d.saturated = 1'b0;
      end else begin
        out_d.res_real  = r0.val;
        out_d.res_imag  = r1.val;
        out_d.saturated = r0.sat | r1.sat;
      end
    end else if (f.sd.op == OP_MAG) begin
      out_d.res_imag  = '0;
      out_d.saturated = (f.sq_r > PosLim);
      out_d.res_real  = out_d.saturated ? PosLim : f.sq_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      itv_q[0]  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      itv_q[0]  <= s3_vld_q;
      out_vld_q <= itv_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= in_word_i;
      s2_q     <= s2_d;
      s3_q     <= s3_d;
      it_q[0]  <= it_d;
      out_q    <= out_d;
    end
  end

  // One quotient bit per lane and one root bit per stage, most significant first.
  for (genvar g = 0; g < DW; g++) begin : g_it
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        itv_q[g+1] <= 1'b0;
      end else if (en) begin
        itv_q[g+1] <= itv_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        it_q[g+1] <= it_step(it_q[g], DW - 1 - g);
      end
    end
  end

endmodule

// ===== design/cau_checker.sv =====
// Port-level checks for the complex arithmetic unit.
// Depends on cau_pkg; bound to complex_arith_unit_core below.
module cau_checker
  import cau_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_word_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_word_o
);

  // The input side stalls only while a result word is held at the output.
  a_stall_cause: assert property (@(posedge clk_i)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output word");

  // A stalled input word stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_word_i)))
    else $error("stalled input word changed");

  // A held result word stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled output word changed");

  // A zero divisor gives a zero result and no saturation.
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.div_zero) |->
      (out_word_o.res_real == '0 && out_word_o.res_imag == '0 &&
       !out_word_o.saturated))
    else $error("divide-by-zero word not cleared");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output word valid right after reset");

endmodule

bind complex_arith_unit_core cau_checker u_cau_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the complex arithmetic unit core.
// It drives random and directed operand words, predicts each result and checks it in order.
// Depends on cau_pkg and complex_arith_unit_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned Latency    = DataWidth + 4;
  localparam logic [2:0]  OpSpare6   = 3'd6;
  localparam logic [2:0]  OpSpare7   = 3'd7;
  localparam logic [31:0] MaxVal     = 32'h7fff_ffff;
  localparam logic [31:0] MinVal     = 32'h8000_0000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_word_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_word_o;

  in_t  pending_words[$];
  out_t expected_results[$];
  int   fail_count   = 0;
  int   idle_cycles  = 0;
  int   in_taken_cnt = 0;
  int   sent_cnt     = 0;
  int   send_gap;
  int   recv_gap;
  int   calm_cycles;

  complex_arith_unit_core u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_word_i,
    .out_valid_o,
    .out_stall_i,
    .out_word_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Signed full product, widened so that sums of products never wrap.
  function automatic wide_t prod(logic signed [31:0] x, logic signed [31:0] y);
    return wide_t'(x) * wide_t'(y);
  endfunction

  function automatic logic [31:0] clip(wide_t v, inout bit flag);
    if (v > wide_t'($signed(MaxVal))) begin
      flag = 1'b1;
      return MaxVal;
    end
    if (v < wide_t'($signed(MinVal))) begin
      flag = 1'b1;
      return MinVal;
    end
    return v[31:0];
  endfunction

  // Quotient rounded to nearest with ties away from zero, then clipped.
  function automatic logic [31:0] quot_part(wide_t num, wide_t den, inout bit flag);
    bit    neg;
    wide_t mag;
    wide_t q;
    neg = num < 0;
    mag = neg ? -num : num;
    q   = ((mag <<< (FracBits + 1)) + den) / (den <<< 1);
    return clip(neg ? -q : q, flag);
  endfunction

  function automatic out_t complex_result(in_t w);
    out_t  r;
    bit    sat;
    wide_t den;
    wide_t sq;
    wide_t root;
    wide_t trial;
    r   = '0;
    sat = 1'b0;
    case (w.op)
      OP_ADD: begin
        r.res_real = clip(wide_t'(w.a_real) + wide_t'(w.b_real), sat);
        r.res_imag = clip(wide_t'(w.a_imag) + wide_t'(w.b_imag), sat);
      end
      OP_SUB: begin
        r.res_real = clip(wide_t'(w.a_real) - wide_t'(w.b_real), sat);
        r.res_imag = clip(wide_t'(w.a_imag) - wide_t'(w.b_imag), sat);
      end
      OP_MUL: begin
        r.res_real = clip((prod(w.a_real, w.b_real) - prod(w.a_imag, w.b_imag)
                           + (wide_t'(1) <<< (FracBits - 1))) >>> FracBits, sat);
        r.res_imag = clip((prod(w.a_real, w.b_imag) + prod(w.a_imag, w.b_real)
                           + (wide_t'(1) <<< (FracBits - 1))) >>> FracBits, sat);
      end
      OP_DIV: begin
        if (w.b_real == 0 && w.b_imag == 0) begin
          r.div_zero = 1'b1;
        end else begin
          den = prod(w.b_real, w.b_real) + prod(w.b_imag, w.b_imag);
          r.res_real = quot_part(prod(w.a_real, w.b_real) + prod(w.a_imag, w.b_imag),
                                 den, sat);
          r.res_imag = quot_part(prod(w.a_imag, w.b_real) - prod(w.a_real, w.b_imag),
                                 den, sat);
        end
      end
      OP_CONJ: begin
        r.res_real = w.a_real;
        r.res_imag = clip(-wide_t'(w.a_imag), sat);
      end
      OP_MAG: begin
        sq   = prod(w.a_real, w.a_real) + prod(w.a_imag, w.a_imag);
        root = 0;
        for (int b = 49; b >= 0; b--) begin
          trial = root | (wide_t'(1) <<< b);
          if (trial * trial <= sq) root = trial;
        end
        r.res_real = clip(root, sat);
      end
      default: ;
    endcase
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    int unsigned pick;
    logic [31:0] v;
    pick = $urandom_range(0, 9);
    case (pick)
      0: v = MaxVal;
      1: v = MinVal;
      2: v = '0;
      3, 4, 5: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic queue_word(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
                            logic [31:0] br, logic [31:0] bi);
    in_t w;
    w.op     = op;
    w.a_real = ar;
    w.a_imag = ai;
    w.b_real = br;
    w.b_imag = bi;
    pending_words.push_back(w);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  function automatic int rand_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm_cycles > 0) return 0;
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: once the offered word has been taken, the next one follows after its gap.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      in_word_i   <= '0;
      out_stall_i <= 1'b0;
      send_gap    <= 0;
      recv_gap    <= 0;
      calm_cycles <= 0;
      sent_cnt    <= 0;
    end else begin
      calm_cycles <= (calm_cycles > 0) ? calm_cycles - 1
                   : (($urandom_range(0, 299) == 0) ? 150 : 0);
      if (!in_valid_i || in_taken_cnt == sent_cnt) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (pending_words.size() > 0) begin
          in_word_i  <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          sent_cnt   <= sent_cnt + 1;
          send_gap   <= rand_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        recv_gap    <= rand_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  // Input acceptance, prediction and the output checker share the rising edge.
  always @(posedge clk_i) begin
    out_t got;
    out_t want;
    bit   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(complex_result(in_word_i));
        in_taken_cnt <= in_taken_cnt + 1;
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        got = out_word_o;
        if (expected_results.size() == 0) begin
          report("unexpected word", got.res_real, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.res_real !== want.res_real) report("res_real", got.res_real, want.res_real);
          if (got.res_imag !== want.res_imag) report("res_imag", got.res_imag, want.res_imag);
          if (got.div_zero !== want.div_zero)
            report("div_zero", {31'b0, got.div_zero}, {31'b0, want.div_zero});
          if (got.saturated !== want.saturated)
            report("saturated", {31'b0, got.saturated}, {31'b0, want.saturated});
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    queue_word(OP_ADD, MaxVal, MinVal, MaxVal, MinVal);
    queue_word(OP_ADD, 32'h0001_8000, 32'hffff_0000, 32'h0000_4000, 32'h0002_0000);
    queue_word(OP_SUB, MinVal, MaxVal, MaxVal, MinVal);
    queue_word(OP_SUB, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0);
    queue_word(OP_MUL, MaxVal, MaxVal, MaxVal, MinVal);
    queue_word(OP_MUL, MinVal, MinVal, MinVal, MinVal);
    queue_word(OP_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0);
    queue_word(OP_MUL, 32'hffff_ffff, 32'h0, 32'h0000_8000, 32'h0);
    queue_word(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    queue_word(OP_DIV, MaxVal, MinVal, 32'h0, 32'h0000_0001);
    queue_word(OP_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    queue_word(OP_DIV, MinVal, MaxVal, MaxVal, MinVal);
    queue_word(OP_DIV, 32'h0000_0001, 32'h0, 32'h0002_0000, 32'h0);
    queue_word(OP_CONJ, MaxVal, MinVal, 32'h0, 32'h0);
    queue_word(OP_CONJ, MinVal, MaxVal, MaxVal, MaxVal);
    queue_word(OP_MAG, MinVal, MinVal, 32'h0, 32'h0);
    queue_word(OP_MAG, 32'h0003_0000, 32'hfffc_0000, 32'h0, 32'h0);
    queue_word(OP_MAG, 32'h0, 32'h0, MaxVal, MinVal);
    queue_word(OpSpare6, MaxVal, MaxVal, MaxVal, MaxVal);
    queue_word(OpSpare7, MinVal, MinVal, MinVal, MinVal);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int n = 0; n < 1030; n++) begin
      if (n == 500) begin
        // Hold off the sender until the pipeline has fully drained once.
        wait (pending_words.size() == 0 && !in_valid_i);
        wait (expected_results.size() == 0);
      end
      queue_word(3'($urandom_range(0, 7)), rand_operand(), rand_operand(),
                 rand_operand(), rand_operand());
    end
    wait (pending_words.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
